>>> rtl/wsuh_pkg.sv
// shared constants and types for the word stream universal hash core
package wsuh_pkg;

  localparam int unsigned FifoDepthDef = 4;

  localparam logic [63:0] HashMult = 64'hff51afd7ed558ccd;

  // index 0 builds bits 31..0 of the mixed word, index 1 builds bits 63..32
  localparam logic [63:0] MixA [2] = '{64'h68b665e6872bd1f4, 64'h65d200ce55b19ad8};
  localparam logic [63:0] MixB [2] = '{64'hb6cfcf9d79b51db2, 64'h4f2162926e40c299};
  localparam logic [63:0] MixC [2] = '{64'h7a2b92ae912898c2, 64'h162dd799029970f8};

  typedef struct packed {
    logic [63:0] mix;
    logic        upd;
    logic        last;
  } entry_t;

endpackage

>>> rtl/wsuh_front.sv
// front end: accepts words, masks bytes and mixes each word into 64 bits
module wsuh_front import wsuh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  output logic        push_o,
  output entry_t      entry_o,
  input  logic        full_i
);

  logic [3:0]  cnt_sat;
  logic [63:0] word_m;
  logic        advance;

  logic        s1_valid_q;
  logic        s1_upd_q;
  logic        s1_last_q;
  logic [63:0] pa_lo_q [2];
  logic [31:0] pa_hi_q [2];
  logic [63:0] pb_lo_q [2];
  logic [31:0] pb_hi_q [2];
  logic [63:0] sum [2];

  always_comb begin
    cnt_sat = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
    for (int i = 0; i < 8; i++) begin
      word_m[8*i +: 8] = (4'(i) < cnt_sat) ? data_word_i[8*i +: 8] : 8'h00;
    end
  end

  assign advance    = !s1_valid_q || !full_i;
  assign in_ready_o = advance;
  assign push_o     = s1_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // partial products of the two multiply-shift hashes, modulo 2^64
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      s1_upd_q  <= (cnt_sat != 4'd0);
      s1_last_q <= last_i;
      for (int k = 0; k < 2; k++) begin
        pa_lo_q[k] <= word_m[31:0] * MixA[k][31:0];
        pa_hi_q[k] <= 32'(word_m[31:0] * MixA[k][63:32]);
        pb_lo_q[k] <= word_m[63:32] * MixB[k][31:0];
        pb_hi_q[k] <= 32'(word_m[63:32] * MixB[k][63:32]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sum[k] = pa_lo_q[k] + {pa_hi_q[k], 32'h0} + pb_lo_q[k] + {pb_hi_q[k], 32'h0}
               + MixC[k];
    end
    entry_o.mix  = {sum[1][63:32], sum[0][63:32]};
    entry_o.upd  = s1_upd_q;
    entry_o.last = s1_last_q;
  end

endmodule

>>> rtl/wsuh_fifo.sv
// short queue of mixed words between front and back
module wsuh_fifo import wsuh_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  entry_t             mem_q [Depth];
  logic [AddrW-1:0]   wr_ptr_q;
  logic [AddrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/wsuh_back.sv
// back end: running hash recurrence and result register
module wsuh_back import wsuh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  entry_t      entry_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);

  typedef enum logic {StIdle, StMul} state_e;

  state_e      state_q;
  logic [63:0] h_q;
  logic [63:0] p0_q;
  logic [31:0] p1_q;
  logic [31:0] p2_q;
  logic        last_q;
  logic        out_valid_q;
  logic [63:0] out_q;

  logic [63:0] x;
  logic [63:0] h_new;
  logic        out_free;
  logic        load_out;

  assign x        = h_q ^ entry_i.mix;
  assign h_new    = p0_q + {32'(p1_q + p2_q), 32'h0};
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == StIdle) && !empty_i
                    && (entry_i.upd || !entry_i.last || out_free);
  assign load_out = (state_q == StIdle) ? (pop_o && !entry_i.upd && entry_i.last)
                                        : (last_q && out_free);

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      h_q         <= HashMult;
      p0_q        <= '0;
      p1_q        <= '0;
      p2_q        <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= load_out || (out_valid_q && !out_ready_i);
      unique case (state_q)
        StIdle: begin
          if (pop_o) begin
            if (entry_i.upd) begin
              p0_q    <= x[31:0] * HashMult[31:0];
              p1_q    <= 32'(x[31:0] * HashMult[63:32]);
              p2_q    <= 32'(x[63:32] * HashMult[31:0]);
              last_q  <= entry_i.last;
              state_q <= StMul;
            end else if (entry_i.last) begin
              out_q <= h_q;
              h_q   <= HashMult;
            end
          end
        end
        StMul: begin
          if (!last_q) begin
            h_q     <= h_new;
            state_q <= StIdle;
          end else if (out_free) begin
            out_q   <= h_new;
            h_q     <= HashMult;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> rtl/word_stream_universal_hash64_core.sv
// top level of the word stream universal hash core
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o | data_word_i, byte_count_i, last_i
//   out     | out_valid_o/out_ready_i | hash_value_o
//
// the front takes one word per cycle while the queue has room and mixes it with a multiply pipeline
// the back folds a word into the running hash (xor, 64-bit multiply) through StIdle and StMul
// a word with bytes blocks the next pop until StMul ends; an empty word is taken in StIdle alone
// result passes front regs, queue, back regs, out_q; an empty last word skips the back regs
// reset loads the running hash with the multiplier and empties the queue
// the queue lets the front keep taking words while the result output is stalled
module word_stream_universal_hash64_core import wsuh_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);

  logic   push;
  logic   full;
  logic   pop;
  logic   empty;
  entry_t front_entry;
  entry_t back_entry;

  wsuh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .push_o       (push),
    .entry_o      (front_entry),
    .full_i       (full)
  );

  wsuh_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (back_entry),
    .empty_o (empty)
  );

  wsuh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (back_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

endmodule
